/* src/gsmd_pkg.sv */
// Shared types and constants of the gray smoothing motion detector.
// No dependencies; used by gsmd_smooth and gray_smooth_motion_detector_top.
package gsmd_pkg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic        was_background;
        logic        motion;
        logic [20:0] differing_pixels;
        logic [31:0] frames_seen;
        logic [31:0] frames_with_motion;
    } result_t;

    // One tap request of the smoothing unit: valid and the enabled taps [row][col].
    typedef struct packed {
        logic             valid;
        logic [2:0][2:0]  mask;
    } take_ctl_t;

    typedef logic [2:0][2:0][7:0] window_t;
    typedef logic [2:0][47:0]     kernel_t;

    localparam int unsigned CFG_W   = 48;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT   = 3'd5;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [20:0] RST_THRESHOLD    = 21'd0;
    localparam logic [47:0] RST_KERNEL_ROW   = 48'h001C_001C_001C;

    // Divide by three: floor(s * 683 / 2048) is exact for s up to 765.
    localparam logic [19:0] GRAY_RECIP = 20'd683;
    localparam int unsigned GRAY_SHIFT = 11;

    function automatic logic [2:0][2:0] tap_mask(input logic [2:0] row_ok,
                                                 input logic [2:0] col_ok);
        logic [2:0][2:0] m;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m[k][j] = row_ok[k] & col_ok[j];
            end
        end
        return m;
    endfunction

endpackage

/* src/gsmd_smooth.sv */
// Two-stage 3x3 smoothing unit: registered tap products, then wrapped sum.
// Depends on gsmd_pkg.
module gsmd_smooth #(
    parameter int unsigned IDX_W = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gsmd_pkg::take_ctl_t req,
    input  gsmd_pkg::window_t   nb,
    input  logic [IDX_W-1:0]    idx,
    input  gsmd_pkg::kernel_t   kernel,
    output logic                busy,
    output logic                out_valid,
    output logic [7:0]          out_value,
    output logic [IDX_W-1:0]    out_idx
);

    logic                    s1_valid_reg;
    logic [2:0][2:0][7:0]    prod_reg;
    logic [2:0][2:0][7:0]    prod_next;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic                    s2_valid_reg;
    logic [7:0]              s2_value_reg;
    logic [7:0]              sum_next;
    logic [IDX_W-1:0]        s2_idx_reg;

    // Keep bits [15:8] of each product: shift by 8, then only the low byte matters.
    always_comb
    begin
        logic [23:0] p;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p = 24'(nb[k][j]) * 24'(kernel[k][16*j +: 16]);
                prod_next[k][j] = req.mask[k][j] ? p[15:8] : 8'd0;
            end
        end
    end

    always_comb
    begin
        sum_next = 8'd0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_next = sum_next + prod_reg[k][j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        s1_idx_reg   <= idx;
        s2_value_reg <= sum_next;
        s2_idx_reg   <= s1_idx_reg;
    end

    assign busy      = s1_valid_reg | s2_valid_reg;
    assign out_valid = s2_valid_reg;
    assign out_value = s2_value_reg;
    assign out_idx   = s2_idx_reg;

endmodule

/* src/gray_smooth_motion_detector_top.sv */
// Gray smoothing motion detector: line store, background memory, sequencer.
// Depends on gsmd_pkg and gsmd_smooth.
// Sequence: a pixel passes idle, window and take states, plus an edge state on the last
//   column of rows after the first; the frame's last pixel adds a last-row flush through
//   the line store read ports, a smoothing/compare drain, then the result.
// Throughput: one pixel in flight at a time, bounded by the per-pixel sequencer.
// Reset: asynchronous, clears sequencer, counters, configuration and result beat;
//   line store and background memory keep no reset and need no clearing pass.
module gray_smooth_motion_detector_top #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  gsmd_pkg::pixel_t                 pix,
    output logic                             res_valid,
    input  logic                             res_stall,
    output gsmd_pkg::result_t                res,
    input  logic                             cfg_write,
    input  logic [gsmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsmd_pkg::CFG_W-1:0]       cfg_data
);

    localparam int unsigned XW       = $clog2(MAX_WIDTH);
    localparam int unsigned YW       = $clog2(MAX_HEIGHT);
    localparam int unsigned FW       = $clog2(MAX_WIDTH + 2);
    localparam int unsigned IDX_W    = XW + YW;
    localparam int unsigned LINE_DEPTH = 2 * (2 ** XW);
    localparam int unsigned BG_DEPTH = MAX_HEIGHT * (2 ** XW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_TAKE,
        S_EDGE,
        S_FLUSH,
        S_DRAIN,
        S_RESULT
    } state_t;

    // Configuration
    logic [10:0]        frame_width_reg;
    logic [10:0]        frame_height_reg;
    logic [20:0]        threshold_reg;
    gsmd_pkg::kernel_t  kernel_reg;

    // Sequencer and counters
    state_t             state_reg;
    logic [XW-1:0]      col_reg;
    logic [YW-1:0]      row_reg;
    logic [FW-1:0]      fcnt_reg;
    logic               loaded_reg;
    logic [20:0]        diff_reg;
    logic [31:0]        frames_reg;
    logic [31:0]        motion_reg;
    logic               res_valid_reg;
    gsmd_pkg::result_t  res_reg;

    // Payload
    logic [7:0]         gray_reg;
    logic [7:0]         gray_next;
    gsmd_pkg::window_t  win_reg;
    logic [7:0]         line_mem [LINE_DEPTH];
    logic [7:0]         rd_a_reg;
    logic [7:0]         rd_b_reg;
    logic [7:0]         bg_mem [BG_DEPTH];
    logic [7:0]         bg_rd_reg;
    logic [7:0]         cmp_value_reg;
    logic               cmp_valid_reg;

    // Derived control
    logic [XW-1:0]      width_last;
    logic [YW-1:0]      height_last;
    logic [XW-1:0]      col_sel;
    logic [XW-1:0]      flush_x;
    logic               accept;
    logic               last_pixel;
    logic               res_load;
    logic               res_free;
    logic               pipe_idle;

    gsmd_pkg::take_ctl_t take_ctl;
    gsmd_pkg::window_t   take_nb;
    logic [IDX_W-1:0]    take_idx;
    logic                sm_busy;
    logic                sm_valid;
    logic [7:0]          sm_value;
    logic [IDX_W-1:0]    sm_idx;

    // Clamp frame dimensions: zero acts as one, oversize acts as the maximum.
    always_comb
    begin
        logic [31:0] w_ext;
        logic [31:0] h_ext;
        logic [31:0] w_last_full;
        logic [31:0] h_last_full;
        w_ext = 32'(frame_width_reg);
        h_ext = 32'(frame_height_reg);
        if (w_ext == 32'd0)
            w_last_full = 32'd0;
        else if (w_ext > 32'(MAX_WIDTH))
            w_last_full = 32'(MAX_WIDTH) - 32'd1;
        else
            w_last_full = w_ext - 32'd1;
        if (h_ext == 32'd0)
            h_last_full = 32'd0;
        else if (h_ext > 32'(MAX_HEIGHT))
            h_last_full = 32'(MAX_HEIGHT) - 32'd1;
        else
            h_last_full = h_ext - 32'd1;
        width_last  = w_last_full[XW-1:0];
        height_last = h_last_full[YW-1:0];
    end

    // Gray = (b + g + r) / 3 through a reciprocal multiply.
    always_comb
    begin
        logic [19:0] sum;
        logic [19:0] prod;
        sum       = 20'(pix.blue) + 20'(pix.green) + 20'(pix.red);
        prod      = sum * gsmd_pkg::GRAY_RECIP;
        gray_next = prod[gsmd_pkg::GRAY_SHIFT +: 8];
    end

    assign pix_stall  = (state_reg != S_IDLE);
    assign accept     = pix_valid && !pix_stall;
    assign last_pixel = (col_reg == width_last) && (row_reg == height_last);
    assign col_sel    = (state_reg == S_FLUSH) ? fcnt_reg[XW-1:0] : col_reg;
    assign flush_x    = XW'(fcnt_reg - FW'(2));
    assign res_free   = !res_valid_reg || !res_stall;
    assign pipe_idle  = !sm_busy && !sm_valid && !cmp_valid_reg;
    assign res_load   = (state_reg == S_RESULT) && res_free;

    // Build smoothing requests. Port A holds the current-parity row, port B the other.
    always_comb
    begin
        take_ctl.valid = 1'b0;
        take_ctl.mask  = '0;
        take_nb        = win_reg;
        take_idx       = {row_reg - YW'(1), col_reg - XW'(1)};
        case (state_reg)
            S_TAKE:
            begin
                take_ctl.valid = (row_reg != '0) && (col_reg != '0);
                take_ctl.mask  = gsmd_pkg::tap_mask({1'b1, 1'b1, row_reg > YW'(1)},
                                                    {1'b1, 1'b1, col_reg > XW'(1)});
            end
            S_EDGE:
            begin
                take_ctl.valid = 1'b1;
                take_ctl.mask  = gsmd_pkg::tap_mask({1'b1, 1'b1, row_reg > YW'(1)},
                                                    {1'b0, 1'b1, width_last != '0});
                for (int k = 0; k < 3; k++)
                begin
                    take_nb[k][0] = win_reg[k][1];
                    take_nb[k][1] = win_reg[k][2];
                    take_nb[k][2] = 8'd0;
                end
                take_idx = {row_reg - YW'(1), col_reg};
            end
            S_FLUSH:
            begin
                // Last row: row above from port B, own row from port A, nothing below.
                take_ctl.valid = (fcnt_reg >= FW'(2));
                take_ctl.mask  = gsmd_pkg::tap_mask({1'b0, 1'b1, row_reg != '0},
                                                    {flush_x != width_last, 1'b1,
                                                     flush_x != '0});
                take_nb[0] = {rd_b_reg, win_reg[0][2], win_reg[0][1]};
                take_nb[1] = {rd_a_reg, win_reg[1][2], win_reg[1][1]};
                take_nb[2] = '0;
                take_idx   = {row_reg, flush_x};
            end
            default:
            begin
                take_ctl.valid = 1'b0;
            end
        endcase
    end

    gsmd_smooth #(
        .IDX_W (IDX_W)
    ) u_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (take_ctl),
        .nb        (take_nb),
        .idx       (take_idx),
        .kernel    (kernel_reg),
        .busy      (sm_busy),
        .out_valid (sm_valid),
        .out_value (sm_value),
        .out_idx   (sm_idx)
    );

    // Line store: two registered reads, one write, read-before-write on a shared entry.
    always_ff @(posedge clk)
    begin
        if (accept)
            line_mem[{row_reg[0], col_reg}] <= gray_next;
        rd_a_reg <= line_mem[{row_reg[0], col_sel}];
        rd_b_reg <= line_mem[{~row_reg[0], col_sel}];
    end

    // Background: write during the first frame, read for compare afterwards.
    always_ff @(posedge clk)
    begin
        if (sm_valid && !loaded_reg)
            bg_mem[sm_idx] <= sm_value;
        bg_rd_reg     <= bg_mem[sm_idx];
        cmp_value_reg <= sm_value;
    end

    // Window and gray pixel
    always_ff @(posedge clk)
    begin
        if (accept)
            gray_reg <= gray_next;
        case (state_reg)
            S_WIN:
            begin
                // Advance one column: row above, row before, new gray.
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= rd_a_reg;
                win_reg[1][2] <= rd_b_reg;
                win_reg[2][2] <= gray_reg;
            end
            S_FLUSH:
            begin
                win_reg[0][1] <= win_reg[0][2];
                win_reg[0][2] <= rd_b_reg;
                win_reg[1][1] <= win_reg[1][2];
                win_reg[1][2] <= rd_a_reg;
            end
            default:
            begin
                win_reg <= win_reg;
            end
        endcase
    end

    // Sequencer, configuration, counters and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            col_reg          <= '0;
            row_reg          <= '0;
            fcnt_reg         <= '0;
            loaded_reg       <= 1'b0;
            diff_reg         <= '0;
            frames_reg       <= '0;
            motion_reg       <= '0;
            cmp_valid_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_reg          <= '0;
            frame_width_reg  <= gsmd_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= gsmd_pkg::RST_FRAME_HEIGHT;
            threshold_reg    <= gsmd_pkg::RST_THRESHOLD;
            kernel_reg       <= {3{gsmd_pkg::RST_KERNEL_ROW}};
        end
        else
        begin
            cmp_valid_reg <= sm_valid && loaded_reg;
            if (cmp_valid_reg && (bg_rd_reg != cmp_value_reg))
                diff_reg <= diff_reg + 21'd1;

            // Raise the result beat when loaded, drop it once taken.
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_WIN;
                end
                S_WIN:
                begin
                    state_reg <= S_TAKE;
                end
                S_TAKE, S_EDGE:
                begin
                    if ((state_reg == S_TAKE) && (row_reg != '0) && (col_reg == width_last))
                        state_reg <= S_EDGE;
                    else if (last_pixel)
                    begin
                        state_reg <= S_FLUSH;
                        fcnt_reg  <= '0;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        if (col_reg == width_last)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + YW'(1);
                        end
                        else
                            col_reg <= col_reg + XW'(1);
                    end
                end
                S_FLUSH:
                begin
                    fcnt_reg <= fcnt_reg + FW'(1);
                    if (fcnt_reg == FW'(width_last) + FW'(2))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (pipe_idle)
                        state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_free)
                    begin
                        col_reg       <= '0;
                        row_reg       <= '0;
                        diff_reg      <= '0;
                        state_reg     <= S_IDLE;
                        if (!loaded_reg)
                        begin
                            loaded_reg                  <= 1'b1;
                            res_reg.was_background     <= 1'b1;
                            res_reg.motion             <= 1'b0;
                            res_reg.differing_pixels   <= '0;
                            res_reg.frames_seen        <= frames_reg;
                            res_reg.frames_with_motion <= motion_reg;
                        end
                        else
                        begin
                            frames_reg                 <= frames_reg + 32'd1;
                            res_reg.was_background     <= 1'b0;
                            res_reg.motion             <= (diff_reg >= threshold_reg);
                            res_reg.differing_pixels   <= diff_reg;
                            res_reg.frames_seen        <= frames_reg + 32'd1;
                            if (diff_reg >= threshold_reg)
                            begin
                                motion_reg                 <= motion_reg + 32'd1;
                                res_reg.frames_with_motion <= motion_reg + 32'd1;
                            end
                            else
                                res_reg.frames_with_motion <= motion_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Dimension writes drop the frame in progress; user must keep it idle (unchecked).
            if (cfg_write)
            begin
                case (cfg_index)
                    gsmd_pkg::CFG_FRAME_WIDTH:
                    begin
                        frame_width_reg <= cfg_data[10:0];
                        col_reg         <= '0;
                        row_reg         <= '0;
                        diff_reg        <= '0;
                    end
                    gsmd_pkg::CFG_FRAME_HEIGHT:
                    begin
                        frame_height_reg <= cfg_data[10:0];
                        col_reg          <= '0;
                        row_reg          <= '0;
                        diff_reg         <= '0;
                    end
                    gsmd_pkg::CFG_THRESHOLD:  threshold_reg <= cfg_data[20:0];
                    gsmd_pkg::CFG_KERNEL_TOP: kernel_reg[0] <= cfg_data;
                    gsmd_pkg::CFG_KERNEL_MID: kernel_reg[1] <= cfg_data;
                    gsmd_pkg::CFG_KERNEL_BOT: kernel_reg[2] <= cfg_data;
                    default:
                    begin
                        threshold_reg <= threshold_reg;
                    end
                endcase
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A result beat is formed only after all smoothing and compares have landed.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!sm_busy && !sm_valid && !cmp_valid_reg))
        else $error("result formed with smoothing work in flight");

    // Compares happen only once a background frame has been stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> loaded_reg)
        else $error("background compare before background loaded");

    // After a result the next frame starts at the origin with a cleared count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (col_reg == '0) && (row_reg == '0) && (diff_reg == '0))
        else $error("frame position not restarted after result");

endmodule

/* test/tb.sv */
// Self-checking testbench of gray_smooth_motion_detector_top: pixel beats in, frame results out.
// Depends on gsmd_pkg and the RTL of the block. It predicts each frame result on its own,
// from a cycle-free model of gray conversion, 3x3 smoothing and background compare.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_W = 1024;
    localparam int unsigned MAX_H = 1024;
    // Largest frame ever sent; the background frame uses exactly this size so that no
    // later frame compares against a background entry that was never stored.
    localparam int unsigned BG_W = 16;
    localparam int unsigned BG_H = 8;
    // Cycles to let pass after the last expected result before touching the registers.
    localparam int unsigned SETTLE_CYCLES = 60;

    logic              clk;
    logic              rst_n;
    logic              pix_valid;
    logic              pix_stall;
    gsmd_pkg::pixel_t  pix;
    logic              res_valid;
    logic              res_stall = 1'b0;
    gsmd_pkg::result_t res;
    logic              cfg_write;
    logic [gsmd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gsmd_pkg::CFG_W-1:0]     cfg_data;

    gray_smooth_motion_detector_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and the frame pipeline of the block.
    // ------------------------------------------------------------------
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [20:0] threshold_reg;
    logic [47:0] kernel_reg [3];

    logic [7:0]  line_buf [2*MAX_W];
    logic [8:0][7:0] gray_win;
    logic [7:0]  bg_mem [MAX_W*MAX_H];
    int unsigned col_pos;
    int unsigned row_pos;
    bit          bg_loaded;
    logic [20:0] diff_cnt;
    logic [31:0] frame_cnt;
    logic [31:0] motion_cnt;

    gsmd_pkg::result_t frame_results_q [$];

    int unsigned pixels_sent;
    int unsigned frames_checked;
    int unsigned error_count;
    bit          calm;          // no idling on either side in the last part of the run
    int unsigned stall_left = 0;

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 0) return 1;
        return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    endfunction

    // Weighted 3x3 sum; taps outside the frame are skipped, the result wraps to 8 bits.
    function automatic logic [7:0] smooth_sum(input logic [8:0][7:0] nb,
                                              input logic [2:0] row_ok,
                                              input logic [2:0] col_ok);
        logic [31:0] sum;
        logic [15:0] coef;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (row_ok[k] && col_ok[j])
                begin
                    coef = kernel_reg[k][16*j +: 16];
                    sum += (32'(nb[k*3+j]) * 32'(coef)) >> 8;
                end
            end
        end
        return sum[7:0];
    endfunction

    // Store into the background, or count a difference against it.
    function automatic void compare_to_background(input int unsigned y, input int unsigned x,
                                                  input logic [7:0] value);
        int unsigned idx;
        idx = (y % MAX_H) * MAX_W + (x % MAX_W);
        if (!bg_loaded)
            bg_mem[idx] = value;
        else if (bg_mem[idx] != value)
            diff_cnt = diff_cnt + 21'd1;
    endfunction

    function automatic void restart_frame();
        col_pos  = 0;
        row_pos  = 0;
        diff_cnt = '0;
        gray_win = '0;
    endfunction

    // Advance the frame model by one accepted pixel; queue a frame result on the last one.
    function automatic void advance_frame(input gsmd_pkg::pixel_t p);
        int unsigned w, h, r, c, up, cur;
        logic [7:0]  g;
        logic [9:0]  rgb_sum;
        logic [8:0][7:0] nb;
        bit          lok, rok, moved;
        gsmd_pkg::result_t exp_res;
        w = active_width();
        h = active_height();
        if (col_pos >= w || row_pos >= h)
            restart_frame();
        r = row_pos;
        c = col_pos;
        rgb_sum = 10'(p.blue) + 10'(p.green) + 10'(p.red);
        g = 8'(rgb_sum / 3);

        for (int k = 0; k < 3; k++)
        begin
            gray_win[k*3]   = gray_win[k*3+1];
            gray_win[k*3+1] = gray_win[k*3+2];
        end
        gray_win[2] = line_buf[(r & 1) * MAX_W + c];
        gray_win[5] = line_buf[((r + 1) & 1) * MAX_W + c];
        gray_win[8] = g;
        line_buf[(r & 1) * MAX_W + c] = g;

        if (r >= 1)
        begin
            if (c >= 1)
                compare_to_background(r - 1, c - 1,
                    smooth_sum(gray_win, {1'b1, 1'b1, r >= 2}, {1'b1, 1'b1, c >= 2}));
            if (c == w - 1)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    nb[k*3]   = gray_win[k*3+1];
                    nb[k*3+1] = gray_win[k*3+2];
                    nb[k*3+2] = 8'd0;
                end
                compare_to_background(r - 1, c,
                    smooth_sum(nb, {1'b1, 1'b1, r >= 2}, {1'b0, 1'b1, w >= 2}));
            end
        end

        if (c == w - 1 && r == h - 1)
        begin
            // Last row has no row below: finish it from the two stored lines.
            up  = ((r + 1) & 1) * MAX_W;
            cur = (r & 1) * MAX_W;
            for (int unsigned x = 0; x < w; x++)
            begin
                lok = x >= 1;
                rok = x + 1 < w;
                nb = '0;
                nb[0] = lok ? line_buf[up + x - 1] : 8'd0;
                nb[1] = line_buf[up + x];
                nb[2] = rok ? line_buf[up + x + 1] : 8'd0;
                nb[3] = lok ? line_buf[cur + x - 1] : 8'd0;
                nb[4] = line_buf[cur + x];
                nb[5] = rok ? line_buf[cur + x + 1] : 8'd0;
                compare_to_background(r, x,
                    smooth_sum(nb, {1'b0, 1'b1, r >= 1}, {rok, 1'b1, lok}));
            end
            if (!bg_loaded)
            begin
                bg_loaded = 1'b1;
                exp_res.was_background   = 1'b1;
                exp_res.motion           = 1'b0;
                exp_res.differing_pixels = '0;
            end
            else
            begin
                moved = diff_cnt >= threshold_reg;
                frame_cnt = frame_cnt + 32'd1;
                if (moved)
                    motion_cnt = motion_cnt + 32'd1;
                exp_res.was_background   = 1'b0;
                exp_res.motion           = moved;
                exp_res.differing_pixels = diff_cnt;
            end
            exp_res.frames_seen        = frame_cnt;
            exp_res.frames_with_motion = motion_cnt;
            frame_results_q.push_back(exp_res);
            col_pos  = 0;
            row_pos  = 0;
            diff_cnt = '0;
        end
        else if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts, and the check of every accepted beat.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        gsmd_pkg::result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (frame_results_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected frame result, actual %p", $realtime, res);
            end
            else
            begin
                want = frame_results_q.pop_front();
                frames_checked++;
                if (res.was_background !== want.was_background)
                begin
                    error_count++;
                    $display("%0t: was_background expected %0d actual %0d",
                             $realtime, want.was_background, res.was_background);
                end
                if (res.motion !== want.motion)
                begin
                    error_count++;
                    $display("%0t: motion expected %0d actual %0d",
                             $realtime, want.motion, res.motion);
                end
                if (res.differing_pixels !== want.differing_pixels)
                begin
                    error_count++;
                    $display("%0t: differing_pixels expected %0d actual %0d",
                             $realtime, want.differing_pixels, res.differing_pixels);
                end
                if (res.frames_seen !== want.frames_seen)
                begin
                    error_count++;
                    $display("%0t: frames_seen expected %0d actual %0d",
                             $realtime, want.frames_seen, res.frames_seen);
                end
                if (res.frames_with_motion !== want.frames_with_motion)
                begin
                    error_count++;
                    $display("%0t: frames_with_motion expected %0d actual %0d",
                             $realtime, want.frames_with_motion, res.frames_with_motion);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel side.
    // ------------------------------------------------------------------

    // Send one pixel beat; enter and leave at a falling edge with valid left high.
    task automatic send_pixel(input gsmd_pkg::pixel_t p);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (pix_stall);
        advance_frame(p);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic release_pixels();
        pix_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly random color, sometimes the field extremes.
    function automatic gsmd_pkg::pixel_t random_pixel();
        gsmd_pkg::pixel_t p;
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            default: p = gsmd_pkg::pixel_t'($urandom);
        endcase
        return p;
    endfunction

    task automatic send_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // Hold until every expected result is in, then let the block settle.
    task automatic wait_idle();
        release_pixels();
        while (frame_results_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; size and threshold data carry upper junk bits the block must drop.
    task automatic write_reg(input logic [gsmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [47:0] value);
        logic [47:0] data;
        data = 48'({$urandom, $urandom});
        case (idx)
            gsmd_pkg::CFG_FRAME_WIDTH:
            begin
                data[10:0] = value[10:0];
                width_reg  = value[10:0];
                restart_frame();
            end
            gsmd_pkg::CFG_FRAME_HEIGHT:
            begin
                data[10:0] = value[10:0];
                height_reg = value[10:0];
                restart_frame();
            end
            gsmd_pkg::CFG_THRESHOLD:
            begin
                data[20:0]    = value[20:0];
                threshold_reg = value[20:0];
            end
            gsmd_pkg::CFG_KERNEL_TOP:
            begin
                data = value;
                kernel_reg[0] = value;
            end
            gsmd_pkg::CFG_KERNEL_MID:
            begin
                data = value;
                kernel_reg[1] = value;
            end
            default:
            begin
                data = value;
                kernel_reg[2] = value;
            end
        endcase
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [47:0] random_kernel_row();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return gsmd_pkg::RST_KERNEL_ROW;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Write each register, most at their extremes, then store the largest frame as background.
    task automatic test_background_frame();
        write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'd2047);
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'd1025);
        write_reg(gsmd_pkg::CFG_THRESHOLD, 48'h1F_FFFF);
        write_reg(gsmd_pkg::CFG_KERNEL_TOP, '1);
        write_reg(gsmd_pkg::CFG_KERNEL_MID, '0);
        write_reg(gsmd_pkg::CFG_KERNEL_BOT, gsmd_pkg::RST_KERNEL_ROW);
        write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'(BG_W));
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'(BG_H));
        send_pixels(BG_W * BG_H);
        wait_idle();
    endtask

    // Zero sizes run as 1x1; full-scale pixels and coefficients; threshold both ways.
    task automatic test_tiny_frames();
        write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'd0);
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'd0);
        write_reg(gsmd_pkg::CFG_THRESHOLD, 48'd0);
        send_pixel('1);
        wait_idle();
        write_reg(gsmd_pkg::CFG_THRESHOLD, 48'd1);
        send_pixel('0);
        wait_idle();
        write_reg(gsmd_pkg::CFG_KERNEL_TOP, '1);
        write_reg(gsmd_pkg::CFG_KERNEL_MID, '1);
        write_reg(gsmd_pkg::CFG_KERNEL_BOT, '1);
        write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'd3);
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'd3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? gsmd_pkg::pixel_t'('1) : gsmd_pkg::pixel_t'('0));
        wait_idle();
        // Single column and single row frames.
        write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'd1);
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'd4);
        send_pixels(4);
        wait_idle();
        write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'd5);
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'd1);
        send_pixels(5);
        wait_idle();
    endtask

    // A size write drops the frame in progress; the next pixel starts a new frame.
    task automatic test_abandoned_frame();
        write_reg(gsmd_pkg::CFG_KERNEL_TOP, gsmd_pkg::RST_KERNEL_ROW);
        write_reg(gsmd_pkg::CFG_KERNEL_MID, gsmd_pkg::RST_KERNEL_ROW);
        write_reg(gsmd_pkg::CFG_KERNEL_BOT, gsmd_pkg::RST_KERNEL_ROW);
        write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'd4);
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'd3);
        send_pixels(6);
        wait_idle();
        write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'd2);
        send_pixels(8);
        wait_idle();
    endtask

    // Random frames with random sizes, kernels and thresholds; some frames cut short.
    task automatic test_random_frames(input int unsigned pixel_goal,
                                      input int unsigned frame_goal);
        int unsigned w, h, n, start_pixels, start_frames;
        start_pixels = pixels_sent;
        start_frames = frames_checked;
        while (pixels_sent - start_pixels < pixel_goal ||
               frames_checked - start_frames < frame_goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                w = BG_W;
                h = BG_H;
            end
            else
            begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 4);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'(w));
                write_reg(gsmd_pkg::CFG_FRAME_HEIGHT, 48'(h));
            end
            w = active_width();
            h = active_height();
            if ($urandom_range(0, 2) == 0)
                write_reg(gsmd_pkg::CFG_KERNEL_TOP +
                          gsmd_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                          random_kernel_row());
            case ($urandom_range(0, 7))
                0: write_reg(gsmd_pkg::CFG_THRESHOLD, 48'h1F_FFFF);
                1, 2, 3: write_reg(gsmd_pkg::CFG_THRESHOLD,
                                   48'($urandom_range(0, w * h + 1)));
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0 && w * h > 1)
            begin
                // Cut the frame short, then restart it with a size write.
                n = $urandom_range(1, w * h - 1);
                send_pixels(n);
                wait_idle();
                write_reg(gsmd_pkg::CFG_FRAME_WIDTH, 48'(w));
            end
            else
            begin
                send_pixels(w * h);
                wait_idle();
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        pix_valid  = 1'b0;
        pix        = '0;
        cfg_write  = 1'b0;
        cfg_index  = gsmd_pkg::CFG_FRAME_WIDTH;
        cfg_data   = '0;
        calm       = 1'b0;
        pixels_sent    = 0;
        frames_checked = 0;
        error_count    = 0;
        width_reg     = gsmd_pkg::RST_FRAME_WIDTH;
        height_reg    = gsmd_pkg::RST_FRAME_HEIGHT;
        threshold_reg = gsmd_pkg::RST_THRESHOLD;
        for (int k = 0; k < 3; k++)
            kernel_reg[k] = gsmd_pkg::RST_KERNEL_ROW;
        for (int i = 0; i < 2 * MAX_W; i++)
            line_buf[i] = 8'd0;
        bg_loaded  = 1'b0;
        frame_cnt  = '0;
        motion_cnt = '0;
        restart_frame();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_background_frame();
        test_tiny_frames();
        test_abandoned_frame();
        test_random_frames(1250, 50);
        // Last part: no idling on either side.
        calm = 1'b1;
        test_random_frames(120, 10);

        wait_idle();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Backstop against a hung handshake.
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
src/gsmd_pkg.sv
src/gsmd_smooth.sv
src/gray_smooth_motion_detector_top.sv
test/tb.sv
